// ----- rtl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths and handshake structs of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int FIELD_W = 32;
	localparam int WIDTH   = 32;
	localparam int CNT_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam int EXT_W   = WIDTH + 2;

	typedef logic [WIDTH-1:0] operand_t;

	typedef struct packed {
		logic     start;
		operand_t a;
		operand_t b;
	} mulred_req_t;

	typedef struct packed {
		logic     busy;
		logic     done;
		operand_t result;
	} mulred_rsp_t;

endpackage

// ----- rtl/mexp_mulred.sv -----
// ----------------------------------------------------------------------------
// mexp_mulred
// Bit-serial interleaved multiply and reduce: a * b mod m, one bit of a per
// cycle, msb first. A zero modulus gives the product wrapped at WIDTH bits.
// ----------------------------------------------------------------------------
module mexp_mulred (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mexp_pkg::mulred_req_t req,
	input  mexp_pkg::operand_t    m,
	output mexp_pkg::mulred_rsp_t rsp
);
	import mexp_pkg::*;

	operand_t         a_q;
	operand_t         b_q;
	operand_t         r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [EXT_W-1:0] sum;
	logic [EXT_W-1:0] m1;
	logic [EXT_W-1:0] m2;
	logic [EXT_W-1:0] d1;
	logic [EXT_W-1:0] d2;
	operand_t         r_next;

	// r < m and b < 3m - 2r keep 2r + b below 3m, so two subtractions at most
	always_comb begin
		sum = {1'b0, r_q, 1'b0} + (a_q[WIDTH-1] ? EXT_W'(b_q) : '0);
		m1  = EXT_W'(m);
		m2  = {1'b0, m, 1'b0};
		d1  = sum - m1;
		d2  = sum - m2;
		priority if (m == '0) begin
			r_next = sum[WIDTH-1:0];
		end else if (sum >= m2) begin
			r_next = d2[WIDTH-1:0];
		end else if (sum >= m1) begin
			r_next = d1[WIDTH-1:0];
		end else begin
			r_next = sum[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[WIDTH-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = r_q;

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base^exponent mod modulus, exponent lsb first
// one reduction pass, then one multiply pass per set exponent bit and one
// squaring pass per shift of the exponent, all through the bit-serial
// multiply-reduce unit; one item at a time, done strobes 1 cycle
// async active-low reset clears control and sets the modulus to 1
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [mexp_pkg::FIELD_W-1:0] base_value,
	input  logic [mexp_pkg::FIELD_W-1:0] exponent,
	input  logic                         wr_en,
	input  logic [mexp_pkg::FIELD_W-1:0] wr_data,
	output logic                         done,
	output logic [mexp_pkg::FIELD_W-1:0] power_mod
);
	import mexp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RED  = 4'b0010,
		S_MUL  = 4'b0100,
		S_SQR  = 4'b1000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [FIELD_W-1:0]   modulus_q;
	operand_t             exp_q;
	operand_t             base_q;
	operand_t             acc_q;
	logic                 done_q;
	logic [FIELD_W-1:0]   power_mod_q;

	mulred_req_t          req;
	mulred_rsp_t          rsp;
	operand_t             exp_shr;

	assign exp_shr = exp_q >> 1;

	mexp_mulred u_mulred (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.m      (modulus_q[WIDTH-1:0]),
		.rsp    (rsp)
	);

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.a     = base_q;
		req.b     = base_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					// base reduction as base * 1
					req.start = 1'b1;
					req.a     = base_value[WIDTH-1:0];
					req.b     = operand_t'(1);
					state_d   = S_RED;
				end
			end
			S_RED: begin
				if (rsp.done) begin
					if (exp_q == '0) begin
						state_d = S_IDLE;
					end else if (exp_q[0]) begin
						req.start = 1'b1;
						req.a     = acc_q;
						req.b     = rsp.result;
						state_d   = S_MUL;
					end else begin
						req.start = 1'b1;
						req.a     = rsp.result;
						req.b     = rsp.result;
						state_d   = S_SQR;
					end
				end
			end
			S_MUL: begin
				if (rsp.done) begin
					if (exp_shr == '0) begin
						state_d = S_IDLE;
					end else begin
						req.start = 1'b1;
						state_d   = S_SQR;
					end
				end
			end
			S_SQR: begin
				// remaining exponent is nonzero here
				if (rsp.done) begin
					req.start = 1'b1;
					req.a     = rsp.result;
					req.b     = rsp.result;
					if (exp_shr[0]) begin
						req.a   = acc_q;
						state_d = S_MUL;
					end else begin
						state_d = S_SQR;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			modulus_q <= FIELD_W'(1);
		end else begin
			state_q <= state_d;
			done_q  <= (state_q != S_IDLE) && (state_d == S_IDLE);
			if (wr_en) begin
				modulus_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					exp_q <= exponent[WIDTH-1:0];
					acc_q <= operand_t'(1);
				end
			end
			S_RED: begin
				if (rsp.done) begin
					base_q <= rsp.result;
					if (exp_q == '0) begin
						power_mod_q <= FIELD_W'(acc_q);
					end
				end
			end
			S_MUL: begin
				if (rsp.done) begin
					acc_q <= rsp.result;
					if (exp_shr == '0) begin
						power_mod_q <= FIELD_W'(rsp.result);
					end
				end
			end
			S_SQR: begin
				if (rsp.done) begin
					base_q <= rsp.result;
					exp_q  <= exp_shr;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign power_mod = power_mod_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start work");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!rsp.busy && !rsp.done))
		else $error("multiply unit active while idle");

	a_unit_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !rsp.done) |-> rsp.busy)
		else $error("busy with no multiply pass running");

endmodule
